>>> rtl/bmpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
`default_nettype none
package bmpc_pkg;

  localparam logic signed [31:0] T_FINE_OFS = 32'sd128000;
  localparam logic [20:0]        P_BASE     = 21'd1048576;
  localparam logic signed [63:0] P_SCALE    = 64'sd3125;
  localparam logic signed [63:0] P1_BIAS    = 64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] P_MAX      = 64'sd4294967295;
  localparam int                 DIV_STAGES = 64;

  typedef enum logic [1:0] {
    REG_TEMP  = 2'd0,
    REG_PRS_A = 2'd1,
    REG_PRS_B = 2'd2,
    REG_PRS_C = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coeff_t;

  typedef struct packed {
    logic signed [15:0] tc;
    logic signed [31:0] v1;
    logic [19:0]        adc_p;
  } temp_beat_t;

  typedef struct packed {
    logic signed [15:0] tc;
    logic signed [63:0] num;
    logic signed [30:0] dv;
  } poly_beat_t;

  typedef struct packed {
    logic [63:0]        q;
    logic [30:0]        rem;
    logic [30:0]        ud;
    logic               neg;
    logic               zero;
    logic signed [15:0] tc;
  } div_beat_t;

  typedef struct packed {
    logic signed [63:0] p;
    logic signed [63:0] ps;
    logic signed [63:0] m1;
    logic signed [63:0] acc;
    logic signed [63:0] c8;
    logic               zero;
    logic signed [15:0] tc;
  } post_beat_t;

endpackage
`default_nettype wire

>>> rtl/bmpc_temp.sv
// Temperature compensation stages: fine temperature, centidegrees and pressure offset term.
`default_nettype none
module bmpc_temp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  bmpc_pkg::in_beat_t    in_data,
  input  bmpc_pkg::coeff_t      coef,
  output logic                  out_vld,
  output bmpc_pkg::temp_beat_t  out_data
);

  logic [3:0]           vld_r;
  logic signed [17:0]   ta;
  logic signed [16:0]   td;
  logic signed [33:0]   x1_nxt;
  logic signed [33:0]   dd_nxt;
  logic signed [33:0]   x1_r;
  logic [31:0]          dd_r;
  logic [19:0]          adc1_r;
  logic signed [22:0]   a_nxt;
  logic signed [36:0]   b_nxt;
  logic signed [22:0]   a_r;
  logic signed [36:0]   b_r;
  logic [19:0]          adc2_r;
  logic signed [31:0]   tf_nxt;
  logic signed [31:0]   tf_r;
  logic [19:0]          adc3_r;
  logic signed [31:0]   t5;
  logic signed [23:0]   tsh;
  bmpc_pkg::temp_beat_t res_nxt;
  bmpc_pkg::temp_beat_t res_r;

  always_comb begin
    ta     = $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
    td     = $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
    x1_nxt = ta * coef.t2;
    dd_nxt = td * td;
    a_nxt  = x1_r[33:11];
    b_nxt  = $signed({1'b0, dd_r[31:12]}) * coef.t3;
    tf_nxt = $signed({{9{a_r[22]}}, a_r}) + $signed({{9{b_r[36]}}, b_r[36:14]});
    t5     = tf_r * 32'sd5 + 32'sd128;
    tsh    = t5[31:8];
    if (tsh > 24'sd32767) begin
      res_nxt.tc = 16'sh7FFF;
    end else if (tsh < -24'sd32768) begin
      res_nxt.tc = 16'sh8000;
    end else begin
      res_nxt.tc = tsh[15:0];
    end
    res_nxt.v1    = tf_r - bmpc_pkg::T_FINE_OFS;
    res_nxt.adc_p = adc3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
    x1_r   <= x1_nxt;
    dd_r   <= dd_nxt[31:0];
    adc1_r <= in_data.raw_pressure;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    adc2_r <= adc1_r;
    tf_r   <= tf_nxt;
    adc3_r <= adc2_r;
    res_r  <= res_nxt;
  end

  assign out_vld  = vld_r[3];
  assign out_data = res_r;

endmodule
`default_nettype wire

>>> rtl/bmpc_poly.sv
// Pressure polynomial stages that form the dividend and the divisor.
`default_nettype none
module bmpc_poly (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  bmpc_pkg::temp_beat_t  in_data,
  input  bmpc_pkg::coeff_t      coef,
  output logic                  out_vld,
  output bmpc_pkg::poly_beat_t  out_data
);

  logic [3:0]           vld_r;
  logic signed [63:0]   vsq_nxt, vp5_nxt, vp2_nxt;
  logic signed [63:0]   vsq_r, vp5_r, vp2_r;
  logic signed [15:0]   tc1_r, tc2_r, tc3_r;
  logic [19:0]          adc1_r, adc2_r;
  logic signed [63:0]   m6, m3, v2_nxt, w_nxt;
  logic signed [63:0]   v2_r, w_r;
  logic [20:0]          pd;
  logic signed [63:0]   x_nxt, pre_nxt;
  logic signed [63:0]   x_r, pre_r;
  bmpc_pkg::poly_beat_t res_nxt;
  bmpc_pkg::poly_beat_t res_r;

  always_comb begin
    vsq_nxt = in_data.v1 * in_data.v1;
    vp5_nxt = in_data.v1 * coef.p5;
    vp2_nxt = in_data.v1 * coef.p2;
    m6      = vsq_r * coef.p6;
    m3      = vsq_r * coef.p3;
    v2_nxt  = m6 + (vp5_r <<< 17) + ($signed({{48{coef.p4[15]}}, coef.p4}) <<< 35);
    w_nxt   = (m3 >>> 8) + (vp2_r <<< 12);
    x_nxt   = (w_r + bmpc_pkg::P1_BIAS) * $signed({1'b0, coef.p1});
    pd      = bmpc_pkg::P_BASE - {1'b0, adc2_r};
    pre_nxt = ($signed({43'd0, pd}) <<< 31) - v2_r;
    res_nxt.tc  = tc3_r;
    res_nxt.num = pre_r * bmpc_pkg::P_SCALE;
    res_nxt.dv  = x_r[63:33];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
    vsq_r  <= vsq_nxt;
    vp5_r  <= vp5_nxt;
    vp2_r  <= vp2_nxt;
    tc1_r  <= in_data.tc;
    adc1_r <= in_data.adc_p;
    v2_r   <= v2_nxt;
    w_r    <= w_nxt;
    tc2_r  <= tc1_r;
    adc2_r <= adc1_r;
    x_r    <= x_nxt;
    pre_r  <= pre_nxt;
    tc3_r  <= tc2_r;
    res_r  <= res_nxt;
  end

  assign out_vld  = vld_r[3];
  assign out_data = res_r;

endmodule
`default_nettype wire

>>> rtl/bmpc_div.sv
// Pipelined signed divider, one quotient bit per stage.
`default_nettype none
module bmpc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  bmpc_pkg::poly_beat_t  in_data,
  output logic                  out_vld,
  output bmpc_pkg::div_beat_t   out_data
);

  logic [bmpc_pkg::DIV_STAGES:0] vld_r;
  bmpc_pkg::div_beat_t           st_r [bmpc_pkg::DIV_STAGES+1];
  bmpc_pkg::div_beat_t           st0_nxt;

  always_comb begin
    st0_nxt.neg  = in_data.num[63] ^ in_data.dv[30];
    st0_nxt.q    = in_data.num[63] ? 64'(64'd0 - in_data.num) : in_data.num;
    st0_nxt.ud   = in_data.dv[30] ? 31'(31'd0 - in_data.dv) : in_data.dv;
    st0_nxt.rem  = '0;
    st0_nxt.zero = (in_data.dv == 31'sd0);
    st0_nxt.tc   = in_data.tc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[bmpc_pkg::DIV_STAGES-1:0], in_vld};
    end
    st_r[0] <= st0_nxt;
  end

  for (genvar k = 0; k < bmpc_pkg::DIV_STAGES; k++) begin : g_stage
    logic [31:0]         trial;
    logic [31:0]         diff;
    bmpc_pkg::div_beat_t nxt;

    always_comb begin
      trial = {st_r[k].rem, st_r[k].q[63]};
      diff  = trial - {1'b0, st_r[k].ud};
      nxt   = st_r[k];
      if (trial >= {1'b0, st_r[k].ud}) begin
        nxt.rem = diff[30:0];
        nxt.q   = {st_r[k].q[62:0], 1'b1};
      end else begin
        nxt.rem = trial[30:0];
        nxt.q   = {st_r[k].q[62:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      st_r[k+1] <= nxt;
    end
  end

  assign out_vld  = vld_r[bmpc_pkg::DIV_STAGES];
  assign out_data = st_r[bmpc_pkg::DIV_STAGES];

endmodule
`default_nettype wire

>>> rtl/bmpc_post.sv
// Post-division correction terms, final scaling and saturation of the pressure.
`default_nettype none
module bmpc_post (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  bmpc_pkg::div_beat_t   in_data,
  input  bmpc_pkg::coeff_t      coef,
  output logic                  out_vld,
  output bmpc_pkg::out_beat_t   out_data
);

  logic [6:0]           vld_r;
  bmpc_pkg::post_beat_t s0_nxt, s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt;
  bmpc_pkg::post_beat_t s0_r, s1_r, s2_r, s3_r, s4_r, s5_r;
  logic signed [63:0]   m8;
  logic [63:0]          pp0;
  logic [63:0]          pp1;
  logic [63:0]          pp2;
  logic signed [63:0]   pf;
  bmpc_pkg::out_beat_t  res_nxt;
  bmpc_pkg::out_beat_t  res_r;

  always_comb begin
    s0_nxt      = '0;
    s0_nxt.p    = in_data.neg ? $signed(64'd0 - in_data.q) : $signed(in_data.q);
    s0_nxt.zero = in_data.zero;
    s0_nxt.tc   = in_data.tc;

    s1_nxt    = s0_r;
    s1_nxt.ps = s0_r.p >>> 13;
    s1_nxt.m1 = coef.p9 * (s0_r.p >>> 13);
    m8        = coef.p8 * s0_r.p;
    s1_nxt.c8 = m8 >>> 19;

    s2_nxt     = s1_r;
    pp0        = s1_r.m1[31:0] * s1_r.ps[31:0];
    s2_nxt.acc = $signed(pp0);

    s3_nxt     = s2_r;
    pp1        = s2_r.m1[31:0] * s2_r.ps[63:32];
    s3_nxt.acc = s2_r.acc + $signed({pp1[31:0], 32'd0});

    s4_nxt     = s3_r;
    pp2        = s3_r.m1[63:32] * s3_r.ps[31:0];
    s4_nxt.acc = s3_r.acc + $signed({pp2[31:0], 32'd0});

    s5_nxt   = s4_r;
    s5_nxt.p = s4_r.p + (s4_r.acc >>> 25) + s4_r.c8;

    pf = (s5_r.p >>> 8) + ($signed({{48{coef.p7[15]}}, coef.p7}) <<< 4);
    res_nxt.temperature_centi = s5_r.tc;
    res_nxt.pressure_valid    = !s5_r.zero;
    if (s5_r.zero || pf < 64'sd0) begin
      res_nxt.pressure_q24_8 = '0;
    end else if (pf > bmpc_pkg::P_MAX) begin
      res_nxt.pressure_q24_8 = '1;
    end else begin
      res_nxt.pressure_q24_8 = pf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s3_nxt;
    s4_r  <= s4_nxt;
    s5_r  <= s5_nxt;
    res_r <= res_nxt;
  end

  assign out_vld  = vld_r[6];
  assign out_data = res_r;

endmodule
`default_nettype wire

>>> rtl/baro_temp_pressure_compensation.sv
// Top level of the barometric temperature and pressure compensation pipeline.
//
//   channel   ports                                   beat
//   input     start, busy, in_data                   one raw temperature and pressure pair
//   result    out_valid, out_data                    centidegrees, Q24.8 pascals, valid flag
//   config    cfg_we, cfg_index, cfg_wdata            one 48-bit calibration register
//
// A new reading pair is taken in every cycle; busy is always low.
// Each result passes through 4 temperature stages, 4 polynomial stages, 65 divider stages
// (a sign and operand set-up stage, then one quotient bit per stage) and 7 correction stages.
// Synchronous reset clears the valid bits and the calibration registers to zero.
// The receiver cannot stall, so results leave the pipeline as they arrive.
`default_nettype none
module baro_temp_pressure_compensation (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bmpc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  output bmpc_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [47:0]          cfg_wdata
);

  logic [47:0]          temp_r, prs_a_r, prs_b_r, prs_c_r;
  bmpc_pkg::coeff_t     coef;
  logic                 tmp_vld, poly_vld, div_vld;
  bmpc_pkg::temp_beat_t tmp_data;
  bmpc_pkg::poly_beat_t poly_data;
  bmpc_pkg::div_beat_t  div_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r  <= '0;
      prs_a_r <= '0;
      prs_b_r <= '0;
      prs_c_r <= '0;
    end else if (cfg_we) begin
      unique case (bmpc_pkg::cfg_reg_t'(cfg_index))
        bmpc_pkg::REG_TEMP:  temp_r  <= cfg_wdata;
        bmpc_pkg::REG_PRS_A: prs_a_r <= cfg_wdata;
        bmpc_pkg::REG_PRS_B: prs_b_r <= cfg_wdata;
        bmpc_pkg::REG_PRS_C: prs_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.t1 = temp_r[15:0];
    coef.t2 = temp_r[31:16];
    coef.t3 = temp_r[47:32];
    coef.p1 = prs_a_r[15:0];
    coef.p2 = prs_a_r[31:16];
    coef.p3 = prs_a_r[47:32];
    coef.p4 = prs_b_r[15:0];
    coef.p5 = prs_b_r[31:16];
    coef.p6 = prs_b_r[47:32];
    coef.p7 = prs_c_r[15:0];
    coef.p8 = prs_c_r[31:16];
    coef.p9 = prs_c_r[47:32];
  end

  assign busy = 1'b0;

  bmpc_temp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_data  (in_data),
    .coef     (coef),
    .out_vld  (tmp_vld),
    .out_data (tmp_data)
  );

  bmpc_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (tmp_vld),
    .in_data  (tmp_data),
    .coef     (coef),
    .out_vld  (poly_vld),
    .out_data (poly_data)
  );

  bmpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (poly_vld),
    .in_data  (poly_data),
    .out_vld  (div_vld),
    .out_data (div_data)
  );

  bmpc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (div_vld),
    .in_data  (div_data),
    .coef     (coef),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
